/* rtl/djc_pkg.sv */
// Shared types, constants and the jet ramp function for depth_to_jet_colour.
// No dependencies; the RTL files refer to this package by scoped names, the benches import it.
package djc_pkg;

    localparam int DEPTH_W       = 16;
    localparam int CHAN_W        = 8;
    localparam int IDX_W         = 10;
    localparam int POS_W         = 11;
    // 1023 * 65535 fits in 26 bits
    localparam int REM_W         = DEPTH_W + IDX_W;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int QUEUE_DEPTH_D = 4;

    localparam logic [DEPTH_W-1:0] FULL_SCALE = 16'hFFFF;
    localparam logic [POS_W-1:0]   RAMP_OFS   = 11'd128;
    localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_MODE = 2'd0,
        REG_WINDOW_LOW  = 2'd1,
        REG_WINDOW_HIGH = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    // Division job: index = floor(1023 * num / den), num <= den, den != 0
    typedef struct packed {
        logic [DEPTH_W-1:0] num;
        logic [DEPTH_W-1:0] den;
    } div_job_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // Piecewise-linear jet ramp at position index + 128 (five 256-step segments)
    function automatic rgb_t jet_ramp(input logic [IDX_W-1:0] idx);
        logic [POS_W-1:0]  pos;
        logic [CHAN_W-1:0] seg;
        rgb_t              c;
        pos = {1'b0, idx} + RAMP_OFS;
        seg = pos[CHAN_W-1:0];
        c   = '0;
        case (pos[POS_W-1:CHAN_W])
            3'd0: begin
                c.blue = seg;
            end
            3'd1: begin
                c.blue  = CHAN_MAX;
                c.green = seg;
            end
            3'd2: begin
                c.blue  = CHAN_MAX - seg;
                c.green = CHAN_MAX;
                c.red   = seg;
            end
            3'd3: begin
                c.green = CHAN_MAX - seg;
                c.red   = CHAN_MAX;
            end
            3'd4: begin
                c.red = CHAN_MAX - seg;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

/* rtl/depth_to_jet_colour.sv */
// Top level of depth_to_jet_colour: depth pixel stream in, jet colour out.
// Instantiates djc_front, djc_queue and djc_back; uses djc_pkg.
//
// Usage:
//   s_ channel carries one 16-bit depth pixel per transaction; m_ channel
//   returns one blue/green/red triple per transaction, in input order.
//   cfg_wr_en/cfg_addr/cfg_wdata write window_mode (0), window_low (1) and
//   window_high (2); other addresses are dropped. Write only while idle.
// Throughput: one pixel per clock, sustained, as long as m_tready stays high.
// Pipeline: an input transaction reaches m_tvalid with an empty queue through
//   the input stage, queue, product stage, ten divider stages and output register.
//   The ten-stage divider yields one quotient bit per stage.
// Stall: when m_tready is low while m_tvalid is high, the back pipeline and output
//   register hold; the queue fills, then the front stage holds and s_tready falls.
// Reset: aresetn (synchronous, active low) empties the pipeline and queue and
//   restores full-range mode with window 0..65535.
module depth_to_jet_colour #(
    parameter int QUEUE_DEPTH = djc_pkg::QUEUE_DEPTH_D
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [djc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [djc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // depth input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [djc_pkg::DEPTH_W-1:0]       s_tdata,   // [15:0] depth
    // colour output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [3*djc_pkg::CHAN_W-1:0]      m_tdata    // [7:0] blue, [15:8] green, [23:16] red
);

    logic              fq_valid;
    logic              fq_ready;
    djc_pkg::div_job_t fq_job;
    logic              qb_valid;
    logic              qb_ready;
    djc_pkg::div_job_t qb_job;

    // Classify each pixel into a division job
    djc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // Decouple front from the stall-all back pipeline
    djc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // Divide, look up the ramp and present the result
    djc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/djc_front.sv */
// Front end of depth_to_jet_colour: configuration registers, input stage and
// classification of each depth sample into a division job. Uses djc_pkg.
module djc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [djc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [djc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [djc_pkg::DEPTH_W-1:0]         s_tdata,
    output logic                                job_valid,
    input  logic                                job_ready,
    output djc_pkg::div_job_t                   job
);

    logic                          mode_reg;
    logic [djc_pkg::DEPTH_W-1:0]   low_reg;
    logic [djc_pkg::DEPTH_W-1:0]   high_reg;
    logic                          valid_reg;
    logic                          valid_next;
    djc_pkg::div_job_t             job_reg;
    djc_pkg::div_job_t             job_next;
    logic [djc_pkg::DEPTH_W-1:0]   clamped;
    logic                          take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            low_reg  <= '0;
            high_reg <= djc_pkg::FULL_SCALE;
        end else if (cfg_wr_en) begin
            case (djc_pkg::cfg_reg_t'(cfg_addr))
                djc_pkg::REG_WINDOW_MODE: mode_reg <= cfg_wdata[0];
                djc_pkg::REG_WINDOW_LOW:  low_reg  <= cfg_wdata[djc_pkg::DEPTH_W-1:0];
                djc_pkg::REG_WINDOW_HIGH: high_reg <= cfg_wdata[djc_pkg::DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Empty window gives 0/1 and inverted window 1/1, so the divider
    // yields 0 and 1023 without a separate path.
    always_comb begin
        clamped = s_tdata;
        if (s_tdata < low_reg) begin
            clamped = low_reg;
        end else if (s_tdata > high_reg) begin
            clamped = high_reg;
        end
        if (!mode_reg) begin
            job_next.num = s_tdata;
            job_next.den = djc_pkg::FULL_SCALE;
        end else if (high_reg == low_reg) begin
            job_next.num = '0;
            job_next.den = djc_pkg::DEPTH_W'(1);
        end else if (high_reg < low_reg) begin
            job_next.num = djc_pkg::DEPTH_W'(1);
            job_next.den = djc_pkg::DEPTH_W'(1);
        end else begin
            job_next.num = clamped - low_reg;
            job_next.den = high_reg - low_reg;
        end
    end

    assign s_tready = !valid_reg || job_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (job_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

/* rtl/djc_queue.sv */
// Short FIFO of division jobs between front and back of depth_to_jet_colour.
// Uses djc_pkg for the job type.
module djc_queue #(
    parameter int QUEUE_DEPTH = djc_pkg::QUEUE_DEPTH_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  djc_pkg::div_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output djc_pkg::div_job_t pop_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    djc_pkg::div_job_t  mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/djc_back.sv */
// Back end of depth_to_jet_colour: pipelined restoring divider (one quotient
// bit per stage), jet ramp and output register. Uses djc_pkg.
module djc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    output logic                             job_ready,
    input  djc_pkg::div_job_t                job,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [3*djc_pkg::CHAN_W-1:0]     m_tdata
);

    localparam int NDIV  = djc_pkg::IDX_W;
    localparam int REM_W = djc_pkg::REM_W;

    logic                          vld_reg [NDIV+1];
    logic [REM_W-1:0]              rem_reg [NDIV+1];
    logic [djc_pkg::DEPTH_W-1:0]   den_reg [NDIV+1];
    logic [djc_pkg::IDX_W-1:0]     quo_reg [NDIV+1];
    logic                          out_valid_reg;
    djc_pkg::rgb_t                 out_rgb_reg;
    logic                          adv;

    // Whole pipeline advances together when the output slot frees up
    assign adv       = !out_valid_reg || m_tready;
    assign job_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= job_valid;
        end
    end

    // 1023 * num as (num << 10) - num
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= {job.num, {djc_pkg::IDX_W{1'b0}}} - REM_W'(job.num);
            den_reg[0] <= job.den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < NDIV; i++) begin : g_div
        localparam int SH = NDIV - 1 - i;
        logic [REM_W:0] trial;

        assign trial = {1'b0, rem_reg[i]} - ((REM_W + 1)'(den_reg[i]) << SH);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i+1] <= trial[REM_W] ? rem_reg[i] : trial[REM_W-1:0];
                den_reg[i+1] <= den_reg[i];
                quo_reg[i+1] <= {quo_reg[i][djc_pkg::IDX_W-2:0], ~trial[REM_W]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_rgb_reg <= djc_pkg::jet_ramp(quo_reg[NDIV]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rgb_reg;

endmodule

/* tb/sv/djc_checker.sv */
// Scoreboard for depth_to_jet_colour: tracks the config writes, predicts each pixel's
// jet colour and compares it with the m_ channel in order. Depends on djc_pkg.
module djc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [djc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [djc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [djc_pkg::DEPTH_W-1:0]       s_tdata,   // [15:0] depth
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [3*djc_pkg::CHAN_W-1:0]      m_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    output int                                mismatches,
    output int                                outstanding
);
    import djc_pkg::*;

    logic               window_on;
    logic [DEPTH_W-1:0] win_low;
    logic [DEPTH_W-1:0] win_high;
    rgb_t               colour_q[$];

    function automatic logic [IDX_W-1:0] depth_to_index(input logic [DEPTH_W-1:0] d);
        int unsigned c;
        int unsigned lo;
        int unsigned hi;
        lo = win_low;
        hi = win_high;
        if (!window_on)
            return IDX_W'((1023 * int'(d)) / 65535);
        if (hi == lo)
            return '0;
        if (hi < lo)
            return '1;
        c = d;
        if (c < lo) c = lo;
        if (c > hi) c = hi;
        return IDX_W'((1023 * (c - lo)) / (hi - lo));
    endfunction

    // five 256-step segments, read at index + 128
    function automatic rgb_t jet_colour(input logic [IDX_W-1:0] idx);
        int unsigned p;
        rgb_t        c;
        p = int'(idx) + 128;
        c = '0;
        if (p < 256) begin
            c.blue = CHAN_W'(p);
        end else if (p < 512) begin
            c.blue  = 8'd255;
            c.green = CHAN_W'(p - 256);
        end else if (p < 768) begin
            c.blue  = CHAN_W'(255 - (p - 512));
            c.green = 8'd255;
            c.red   = CHAN_W'(p - 512);
        end else if (p < 1024) begin
            c.green = CHAN_W'(255 - (p - 768));
            c.red   = 8'd255;
        end else begin
            c.red = CHAN_W'(255 - (p - 1024));
        end
        return c;
    endfunction

    task automatic check_channel(input string chan, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, chan, want, got);
        end
    endtask

    always @(posedge aclk) begin
        rgb_t want;
        if (!aresetn) begin
            window_on   <= 1'b0;
            win_low     <= '0;
            win_high    <= FULL_SCALE;
            colour_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_WINDOW_MODE: window_on <= cfg_wdata[0];
                    REG_WINDOW_LOW:  win_low   <= cfg_wdata;
                    REG_WINDOW_HIGH: win_high  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (colour_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: colour expected none actual %h", $time, m_tdata);
                end else begin
                    want = colour_q.pop_front();
                    check_channel("blue",  want.blue,  m_tdata[7:0]);
                    check_channel("green", want.green, m_tdata[15:8]);
                    check_channel("red",   want.red,   m_tdata[23:16]);
                end
            end
            if (s_tvalid && s_tready)
                colour_q.push_back(jet_colour(depth_to_index(s_tdata)));
            outstanding = colour_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for depth_to_jet_colour: clock, reset, bursty depth stimulus,
// stalling colour sink and config writes. Depends on djc_pkg and djc_checker.
module tb_top;
    import djc_pkg::*;

    localparam bit MODE_FULL   = 1'b0;
    localparam bit MODE_WINDOW = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;     // longer than the pipeline latency
    localparam int HOLD_CYCLES = 100;    // long sink stall to back up the queue
    localparam int HOLD_AFTER  = 300;    // pixels sent before that stall starts
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 135;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [DEPTH_W-1:0]      s_tdata;    // [15:0] depth
    logic                    m_tvalid;
    logic                    m_tready;
    logic [3*CHAN_W-1:0]     m_tdata;    // [7:0] blue, [15:8] green, [23:16] red

    int mismatches;
    int outstanding;
    int sent_count;
    int setting_count;
    int cycle_count;
    int burst_left;
    int gap_max;
    bit hold_done;

    depth_to_jet_colour DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    djc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog: give up if the run stalls somewhere
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one depth pixel and hold it until the transaction completes. Entered and
    // left at a falling edge; a new burst may open with a random gap first.
    task automatic send_depth(input logic [DEPTH_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        burst_left--;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent_count++;
    endtask

    // Drain the block, then write all three registers plus the unused index.
    // The mode write carries random upper bits, which the block must drop.
    task automatic set_window(input bit mode, input logic [DEPTH_W-1:0] lo,
                              input logic [DEPTH_W-1:0] hi);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = REG_WINDOW_MODE;
        cfg_wdata = {15'($urandom), mode};
        @(negedge aclk);
        cfg_addr  = REG_WINDOW_LOW;
        cfg_wdata = lo;
        @(negedge aclk);
        cfg_addr  = REG_WINDOW_HIGH;
        cfg_wdata = hi;
        @(negedge aclk);
        cfg_addr  = REG_UNUSED;
        cfg_wdata = 16'($urandom);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        setting_count++;
    endtask

    // Random depth biased toward the window edges and the 16-bit extremes
    function automatic logic [DEPTH_W-1:0] pick_depth(input int lo, input int hi);
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? 65535 : 0;
            1, 2:    v = $urandom_range(0, 65535);
            3:       v = $urandom_range(0, 1) ? hi : lo;
            4:       v = ($urandom_range(0, 1) ? hi : lo) + $urandom_range(0, 4) - 2;
            default: v = $urandom_range(hi, lo);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return DEPTH_W'(v);
    endfunction

    // Sink: stretches of random length, each with its own ready pattern
    // (always ready, coin flip, mostly ready, one in three). One long hold-off
    // once enough pixels have gone in, while the source keeps offering.
    initial begin
        int stretch;
        int pattern;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stretch = $urandom_range(10, 120);
            pattern = $urandom_range(0, 3);
            for (int i = 0; i < stretch; i++) begin
                @(negedge aclk);
                if (!hold_done && sent_count >= HOLD_AFTER) begin
                    m_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    hold_done = 1'b1;
                end
                case (pattern)
                    0:       m_tready = 1'b1;
                    1:       m_tready = $urandom_range(0, 1);
                    2:       m_tready = ($urandom_range(0, 9) != 0);
                    default: m_tready = (i % 3 == 0);
                endcase
            end
        end
    end

    initial begin
        logic [DEPTH_W-1:0] full_range_pts[$];
        int lo;
        int hi;
        bit mode;

        full_range_pts = '{16'd0, 16'd1, 16'd64, 16'd65535,
            16'd65534, 16'd32767, 16'd32768, 16'd8199, 16'd8200, 16'd24599,
            16'd24600, 16'd40999, 16'd41000, 16'd58399, 16'd58400};
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = REG_WINDOW_MODE;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_left = 0;
        gap_max    = 3;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: full range at reset values, extremes and three of the four ramp segment edges
        foreach (full_range_pts[k]) send_depth(full_range_pts[k]);
        // clamp below, at and above a small window
        set_window(MODE_WINDOW, 16'd1000, 16'd2000);
        send_depth(16'd999);
        send_depth(16'd1000);
        send_depth(16'd1001);
        send_depth(16'd2000);
        send_depth(16'd2001);
        // empty window gives the first colour
        set_window(MODE_WINDOW, 16'd30000, 16'd30000);
        send_depth(16'd0);
        send_depth(16'd65535);
        // inverted window gives the last colour
        set_window(MODE_WINDOW, 16'd65535, 16'd0);
        send_depth(16'd0);
        send_depth(16'd65535);

        // Random phases, one register setting each
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = MODE_WINDOW;
            lo   = $urandom_range(0, 65535);
            hi   = $urandom_range(lo, 65535);
            case (ph)
                0, 7: mode = MODE_FULL;
                2: begin
                    lo = 0;
                    hi = 65535;
                end
                3: begin
                    hi = lo + $urandom_range(1, 8);
                    if (hi > 65535) begin
                        hi = 65535;
                        lo = 65535 - $urandom_range(1, 8);
                    end
                end
                4: hi = lo;
                5: begin
                    lo = $urandom_range(1, 65535);
                    hi = $urandom_range(0, lo - 1);
                end
                6: hi = $urandom_range(0, 65535);
                8: begin
                    lo = $urandom_range(0, 60000);
                    hi = lo + $urandom_range(500, 2000);
                end
                default: ;
            endcase
            set_window(mode, DEPTH_W'(lo), DEPTH_W'(hi));
            // every third phase runs back to back with no source gaps
            gap_max = (ph % 3 == 0) ? 0 : 6;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_depth(pick_depth(lo, hi));
        end

        // Drain and let the pipeline settle before the verdict
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);

        $display("Ran %0d depth pixels under %0d register settings: full range,", sent_count,
                 setting_count);
        $display("clamped, narrow, empty and inverted windows, with bursts and sink stalls");
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
